[design/u16u8_pkg.sv]
// Package for the UTF-16 to UTF-8 transcoder: field widths, surrogate
// ranges, configuration register codes, the staged-item record and the encoder.
// No dependencies.
package u16u8_pkg;

  // Field and register widths
  localparam int UNIT_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int TOTAL_W     = 24;
  localparam int CAP_W       = 24;
  localparam int COUNT_WIDTH = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;
  localparam int CP_W        = 21;

  // Compare width: holds either count or capacity plus a few bytes
  localparam int CMP_W = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;

  // Bytes one item may produce: an unpaired held unit plus a 3-byte character
  localparam int JOB_SLOTS = 6;
  localparam int SLOT_W    = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 1'b1;

  // Surrogate ranges and special code points
  localparam logic [UNIT_W-1:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE     = 21'h10000;
  localparam logic [CP_W-1:0]   REPLACEMENT   = 21'h0FFFD;
  localparam logic [CP_W-1:0]   MAX_ONE_BYTE  = 21'h0007F;
  localparam logic [CP_W-1:0]   MAX_TWO_BYTE  = 21'h007FF;
  localparam logic [CP_W-1:0]   MAX_BMP       = 21'h0FFFF;
  localparam logic [2:0]        UNPAIRED_SIZE = 3'd3;

  // One encoded character: byte count (0 for code point zero) and bytes
  typedef struct packed {
    logic [2:0]             size;
    logic [3:0][BYTE_W-1:0] b;
  } char_t;

  // One accepted item waiting to be sent out byte by byte
  typedef struct packed {
    logic [JOB_SLOTS-1:0][BYTE_W-1:0] bytes;
    logic [SLOT_W-1:0]                n;
    logic [SLOT_W-1:0]                emit;
    logic                             last;
    logic [COUNT_WIDTH-1:0]           base;
  } job_t;

  // One result beat
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               has_byte;
    logic               run_last;
    logic               region_done;
    logic [TOTAL_W-1:0] total_bytes;
  } result_t;

  // Encode a code point as UTF-8; bytes beyond size are zero
  function automatic char_t encode(input logic [CP_W-1:0] cp);
    char_t c;
    c = '0;
    if (cp == '0) begin
      c.size = 3'd0;
    end else if (cp <= MAX_ONE_BYTE) begin
      c.size = 3'd1;
      c.b[0] = {1'b0, cp[6:0]};
    end else if (cp <= MAX_TWO_BYTE) begin
      c.size = 3'd2;
      c.b[0] = {3'b110, cp[10:6]};
      c.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= MAX_BMP) begin
      c.size = 3'd3;
      c.b[0] = {4'b1110, cp[15:12]};
      c.b[1] = {2'b10, cp[11:6]};
      c.b[2] = {2'b10, cp[5:0]};
    end else begin
      c.size = 3'd4;
      c.b[0] = {5'b11110, cp[20:18]};
      c.b[1] = {2'b10, cp[17:12]};
      c.b[2] = {2'b10, cp[11:6]};
      c.b[3] = {2'b10, cp[5:0]};
    end
    return c;
  endfunction

  // Region byte count as seen on the total_bytes field
  function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_WIDTH-1:0] cnt);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(cnt);
    return wide[TOTAL_W-1:0];
  endfunction

endpackage

[design/u16u8_unit_if.sv]
// Input channel of the transcoder: one UTF-16 code unit per beat.
// Depends on u16u8_pkg for field widths.
interface u16u8_unit_if import u16u8_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              last_unit;

  modport source (output valid, code_unit, last_unit, input ready);
  modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

[design/u16u8_byte_if.sv]
// Output channel of the transcoder: one UTF-8 byte or end marker per beat.
// Depends on u16u8_pkg for field widths.
interface u16u8_byte_if import u16u8_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               has_byte;
  logic               run_last;
  logic               region_done;
  logic [TOTAL_W-1:0] total_bytes;

  modport source (output valid, out_byte, has_byte, run_last, region_done, total_bytes,
                  input ready);
  modport sink   (input valid, out_byte, has_byte, run_last, region_done, total_bytes,
                  output ready);
endinterface

[design/utf16_to_utf8_transcoder.sv]
// UTF-16 to UTF-8 transcoder, top level.
// Depends on u16u8_pkg, u16u8_unit_if and u16u8_byte_if.
//
// Usage:
//   units : valid/ready input, one UTF-16 code unit per beat, last_unit marks
//           the end of a region.
//   utf8  : valid/ready output, one UTF-8 byte per beat; the final beat of a
//           region has region_done set, and is a byteless marker (has_byte 0)
//           when the last unit produced nothing.
//   cfg_* : write port, index 0 selects U+FFFD for unpaired surrogates,
//           index 1 sets the per-region byte capacity. Write only while idle.
// Timing:
//   A unit is decoded at acceptance into a staging register that holds up to
//   six bytes; the bytes leave through an output register one per cycle
//   while utf8.ready is high. Between acceptance and the first result lie the
//   staging and output registers. A new unit is taken as the last beat of the
//   staged one loads. A high surrogate produces nothing until the next unit.
// Reset: rst clears the configuration to defaults, drops any held surrogate,
//   zeroes the byte count and empties both stages.
// Stall: with utf8.ready low the output register holds its beat; one more
//   unit can still be staged behind it before units.ready drops.
module utf16_to_utf8_transcoder import u16u8_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  u16u8_unit_if.sink             units,
  u16u8_byte_if.source           utf8
);

  // Configuration registers
  logic             replace_unpaired;
  logic [CAP_W-1:0] out_capacity;

  // Region state
  logic [UNIT_W-1:0]      held_high;
  logic                   held_valid;
  logic [COUNT_WIDTH-1:0] bytes_written;

  // Staging and output stages
  job_t              job;
  logic              job_valid;
  logic [SLOT_W-1:0] job_idx;
  result_t           res;
  logic              res_valid;

  // Decode signals
  logic                   in_fire;
  logic                   is_high;
  logic                   is_low;
  logic                   pair;
  logic                   c1_on;
  logic [CP_W-1:0]        c1_cp;
  logic [CP_W-1:0]        c2_cp;
  char_t                  c1;
  char_t                  c2;
  logic [CMP_W-1:0]       bw_x;
  logic [CMP_W-1:0]       cap_x;
  logic                   fit1;
  logic                   fit2;
  logic [SLOT_W-1:0]      n1;
  logic [SLOT_W-1:0]      n2;
  job_t                   job_next;
  logic [COUNT_WIDTH-1:0] bytes_written_next;

  // Emission control
  logic    res_load;
  logic    job_final;
  result_t res_next;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_unpaired <= 1'b0;
      out_capacity     <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLACE:  replace_unpaired <= cfg_data[0];
        CFG_CAPACITY: out_capacity     <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming unit and pick up to two characters
  always_comb begin
    is_high = (units.code_unit >= HIGH_SURR_MIN) && (units.code_unit <= HIGH_SURR_MAX);
    is_low  = (units.code_unit >= LOW_SURR_MIN) && (units.code_unit <= LOW_SURR_MAX);
    pair    = held_valid && is_low;
    c1_on   = held_valid && !is_low;
    c1_cp   = replace_unpaired ? REPLACEMENT : CP_W'(held_high);

    if (pair) begin
      c2_cp = CP_W'({held_high[9:0], units.code_unit[9:0]}) + SUPP_BASE;
    end else if (is_high && !units.last_unit) begin
      c2_cp = '0;
    end else if ((is_high || is_low) && replace_unpaired) begin
      c2_cp = REPLACEMENT;
    end else begin
      c2_cp = CP_W'(units.code_unit);
    end

    c1 = encode(c1_cp);
    c2 = encode(c2_cp);
  end

  // Check capacity for both characters in parallel and pack the bytes
  always_comb begin
    bw_x  = CMP_W'(bytes_written);
    cap_x = CMP_W'(out_capacity);
    fit1  = c1_on && (bw_x + CMP_W'(UNPAIRED_SIZE) <= cap_x);
    if (fit1) begin
      fit2 = (c2.size != 3'd0) &&
             (bw_x + CMP_W'(UNPAIRED_SIZE) + CMP_W'(c2.size) <= cap_x);
    end else begin
      fit2 = (c2.size != 3'd0) && (bw_x + CMP_W'(c2.size) <= cap_x);
    end
    n1 = fit1 ? SLOT_W'(UNPAIRED_SIZE) : '0;
    n2 = fit2 ? SLOT_W'(c2.size) : '0;

    job_next = '0;
    if (fit1) begin
      job_next.bytes[0] = c1.b[0];
      job_next.bytes[1] = c1.b[1];
      job_next.bytes[2] = c1.b[2];
      if (fit2) begin
        job_next.bytes[3] = c2.b[0];
        job_next.bytes[4] = c2.b[1];
        job_next.bytes[5] = c2.b[2];
      end
    end else if (fit2) begin
      job_next.bytes[0] = c2.b[0];
      job_next.bytes[1] = c2.b[1];
      job_next.bytes[2] = c2.b[2];
      job_next.bytes[3] = c2.b[3];
    end
    job_next.n    = n1 + n2;
    job_next.emit = ((job_next.n == '0) && units.last_unit) ? SLOT_W'(1) : job_next.n;
    job_next.last = units.last_unit;
    job_next.base = bytes_written;

    bytes_written_next = units.last_unit ? '0 : bytes_written + COUNT_WIDTH'(job_next.n);
  end

  // Handshake between the stages
  assign res_load    = job_valid && (!res_valid || utf8.ready);
  assign job_final   = (job_idx == job.emit - SLOT_W'(1));
  assign units.ready = !job_valid || (res_load && job_final);
  assign in_fire     = units.valid && units.ready;

  // Advance region state on each accepted unit
  always_ff @(posedge clk) begin
    if (rst) begin
      held_high     <= '0;
      held_valid    <= 1'b0;
      bytes_written <= '0;
    end else if (in_fire) begin
      bytes_written <= bytes_written_next;
      if (units.last_unit) begin
        held_high  <= '0;
        held_valid <= 1'b0;
      end else if (is_high && !pair) begin
        held_high  <= units.code_unit;
        held_valid <= 1'b1;
      end else begin
        held_valid <= 1'b0;
      end
    end
  end

  // Stage the item; drop it at once when it makes no beat
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= '0;
    end else if (in_fire) begin
      job_valid <= (job_next.emit != '0);
      job_idx   <= '0;
    end else if (res_load && job_final) begin
      job_valid <= 1'b0;
    end else if (res_load) begin
      job_idx <= job_idx + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      job <= job_next;
    end
  end

  // Form the next result beat from the staged item
  always_comb begin
    res_next.has_byte    = (job.n != '0);
    res_next.out_byte    = res_next.has_byte ? job.bytes[job_idx] : '0;
    res_next.run_last    = job_final;
    res_next.region_done = job.last && job_final;
    res_next.total_bytes = res_next.has_byte ?
                           to_total(job.base + COUNT_WIDTH'(job_idx) + COUNT_WIDTH'(1)) :
                           to_total(job.base);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (utf8.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  assign utf8.valid       = res_valid;
  assign utf8.out_byte    = res.out_byte;
  assign utf8.has_byte    = res.has_byte;
  assign utf8.run_last    = res.run_last;
  assign utf8.region_done = res.region_done;
  assign utf8.total_bytes = res.total_bytes;

`ifndef ASSERT_OFF
  // Staged index never runs past the beats of its item
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_idx < job.emit))
    else $error("staged index beyond item beat count");

  // Region end is always the last beat of its unit
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.region_done |-> res.run_last)
    else $error("region_done without run_last");

  // A byteless beat only closes a region
  a_byteless: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_byte |-> res.region_done && res.run_last)
    else $error("byteless beat outside region end");

  // A last unit clears the held surrogate and the byte count
  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    units.valid && units.ready && units.last_unit |=> !held_valid && (bytes_written == '0))
    else $error("region state not cleared after last unit");
`endif

endmodule

[tb/tb_utf16_to_utf8_transcoder.sv]
// Self-checking testbench for utf16_to_utf8_transcoder: directed table, then random regions.
// Depends on u16u8_pkg and the u16u8_unit_if / u16u8_byte_if channel interfaces.
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder;
  import u16u8_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_UNITS    = 22;
  localparam int DIR_ROWS       = 31;
  localparam int MAX_PRINTS     = 50;

  // Surrogate ranges and special code points, kept apart from the design's copies
  localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_FIRST    = 21'h10000;
  localparam logic [20:0] REPLACE_CHAR  = 21'h0FFFD;
  localparam logic [23:0] CAP_FULL      = 24'hFFFFFF;

  typedef enum logic {ROW_UNIT, ROW_CONFIG} row_kind_e;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  // One directed step: a code unit (optionally with its bytes typed in) or a register setting
  typedef struct {
    row_kind_e   kind;
    logic [15:0] code_unit;
    logic        last_unit;
    logic        typed;
    logic [2:0]  ref_n;
    logic [31:0] ref_seq;
    logic        cfg_replace;
    logic [23:0] cfg_capacity;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  u16u8_unit_if unit_ch();
  u16u8_byte_if utf8_ch();

  utf16_to_utf8_transcoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .units     (unit_ch),
    .utf8      (utf8_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Typed expectation travels with the unit beat so the monitor samples it at acceptance
  logic        row_typed;
  logic [2:0]  row_ref_n;
  logic [31:0] row_ref_seq;

  // Transcoder state mirror
  logic                   mode_replace;
  logic [23:0]            cap_limit;
  logic [15:0]            pend_high;
  logic                   pend_valid;
  logic [COUNT_WIDTH-1:0] region_bytes;
  logic [7:0]             step_bytes[$];
  logic [TOTAL_W-1:0]     step_totals[$];
  result_t                utf8_expect_q[$];

  int  mismatches = 0;
  int  units_accepted = 0;
  int  burst_left = 1;
  int  quiet_cycles = 0;
  bit  sender_steady = 1'b0;
  bit  rx_hold_req = 1'b0;

  stim_row_t dir_rows [0:DIR_ROWS-1];

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t ns: %s", $time, msg);
  endtask

  // Encode one code point and append its bytes if the region still has room
  task automatic emit_code_point(input logic [20:0] cp);
    logic [7:0] enc [4];
    int len;
    longint unsigned need;
    enc = '{default: 8'h00};
    if (cp == 21'd0) begin
      len = 0;
    end else if (cp <= 21'h00007F) begin
      len = 1;
      enc[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h0007FF) begin
      len = 2;
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h00FFFF) begin
      len = 3;
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
    end else begin
      len = 4;
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
    end
    need = region_bytes;
    need = need + len;
    // Drop the whole character when it would overrun the capacity
    if (len > 0 && need <= cap_limit) begin
      for (int k = 0; k < len; k++) begin
        region_bytes = region_bytes + 1'b1;
        step_bytes.push_back(enc[k]);
        step_totals.push_back(region_bytes[TOTAL_W-1:0]);
      end
    end
  endtask

  task automatic emit_unpaired(input logic [15:0] cu);
    emit_code_point(mode_replace ? REPLACE_CHAR : {5'd0, cu});
  endtask

  // Work out the beats one accepted code unit causes and queue them
  task automatic predict_unit(input logic [15:0] cu, input logic lu, input logic typed,
                              input logic [2:0] n_ref, input logic [31:0] seq_ref);
    logic        is_hi;
    logic        is_lo;
    logic [20:0] cp;
    result_t     r;
    int          n;
    step_bytes.delete();
    step_totals.delete();
    is_hi = (cu >= SURR_HI_FIRST) && (cu <= SURR_HI_LAST);
    is_lo = (cu >= SURR_LO_FIRST) && (cu <= SURR_LO_LAST);
    if (pend_valid && is_lo) begin
      pend_valid = 1'b0;
      cp = (21'(pend_high - SURR_HI_FIRST) << 10) + 21'(cu - SURR_LO_FIRST) + SUPP_FIRST;
      emit_code_point(cp);
    end else begin
      // Flush a held high surrogate that did not pair
      if (pend_valid) begin
        pend_valid = 1'b0;
        emit_unpaired(pend_high);
      end
      if (is_hi) begin
        if (lu) begin
          emit_unpaired(cu);
        end else begin
          pend_high  = cu;
          pend_valid = 1'b1;
        end
      end else if (is_lo) begin
        emit_unpaired(cu);
      end else begin
        emit_code_point({5'd0, cu});
      end
    end
    n = step_bytes.size();
    r = '0;
    if (typed) begin
      // Typed rows always end a fresh region
      if (n_ref == 3'd0) begin
        r.run_last    = 1'b1;
        r.region_done = 1'b1;
        utf8_expect_q.push_back(r);
      end
      for (int k = 0; k < n_ref; k++) begin
        r.out_byte    = seq_ref[31 - 8 * k -: 8];
        r.has_byte    = 1'b1;
        r.run_last    = (k == n_ref - 1);
        r.region_done = (k == n_ref - 1);
        r.total_bytes = TOTAL_W'(k + 1);
        utf8_expect_q.push_back(r);
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        r.out_byte    = step_bytes[k];
        r.has_byte    = 1'b1;
        r.run_last    = (k == n - 1);
        r.region_done = lu && (k == n - 1);
        r.total_bytes = step_totals[k];
        utf8_expect_q.push_back(r);
      end
      if (lu && n == 0) begin
        r             = '0;
        r.run_last    = 1'b1;
        r.region_done = 1'b1;
        r.total_bytes = region_bytes[TOTAL_W-1:0];
        utf8_expect_q.push_back(r);
      end
    end
    // Close the region
    if (lu) begin
      pend_high    = '0;
      pend_valid   = 1'b0;
      region_bytes = '0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("utf8 beat %s: got 0x%0h, expected 0x%0h",
                                name, got_v, want_v));
  endtask

  task automatic check_utf8_beat(input result_t got);
    result_t want;
    if (utf8_expect_q.size() == 0) begin
      report_mismatch($sformatf("unexpected utf8 beat: byte 0x%0h has_byte %0b total %0d",
                                got.out_byte, got.has_byte, got.total_bytes));
    end else begin
      want = utf8_expect_q.pop_front();
      compare_field("out_byte", got.out_byte, want.out_byte);
      compare_field("has_byte", got.has_byte, want.has_byte);
      compare_field("run_last", got.run_last, want.run_last);
      compare_field("region_done", got.region_done, want.region_done);
      compare_field("total_bytes", got.total_bytes, want.total_bytes);
    end
  endtask

  // Sample both channels on the edge; check output beats, predict accepted units
  always @(posedge clk) begin : beat_monitor
    result_t beat;
    if (!rst) begin
      if (utf8_ch.valid && utf8_ch.ready) begin
        beat.out_byte    = utf8_ch.out_byte;
        beat.has_byte    = utf8_ch.has_byte;
        beat.run_last    = utf8_ch.run_last;
        beat.region_done = utf8_ch.region_done;
        beat.total_bytes = utf8_ch.total_bytes;
        check_utf8_beat(beat);
      end
      if (unit_ch.valid && unit_ch.ready)
        predict_unit(unit_ch.code_unit, unit_ch.last_unit, row_typed, row_ref_n, row_ref_seq);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (unit_ch.valid && unit_ch.ready) || (utf8_ch.valid && utf8_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("** utf16_to_utf8_transcoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: rotate between open, random and periodic stall patterns; long hold on request
  initial begin : rx_pacing
    rx_mode_e mode;
    int span;
    int tick;
    utf8_ch.ready <= 1'b0;
    mode = RX_OPEN;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        utf8_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          span = $urandom_range(16, 64);
        end
        span--;
        tick++;
        case (mode)
          RX_OPEN:   utf8_ch.ready <= 1'b1;
          RX_RANDOM: utf8_ch.ready <= ($urandom_range(0, 99) >= 35);
          default:   utf8_ch.ready <= ((tick % 5) >= 2);
        endcase
      end
    end
  end

  // Offer one unit, hold it until accepted, then maybe open a gap
  task automatic send_unit(input logic [15:0] cu, input logic lu, input logic typed,
                           input logic [2:0] n_ref, input logic [31:0] seq_ref);
    int gap;
    unit_ch.valid     <= 1'b1;
    unit_ch.code_unit <= cu;
    unit_ch.last_unit <= lu;
    row_typed         <= typed;
    row_ref_n         <= n_ref;
    row_ref_seq       <= seq_ref;
    @(posedge clk);
    while (!unit_ch.ready) @(posedge clk);
    units_accepted++;
    if (!sender_steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          unit_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Stop offering and wait until every expected beat has arrived, then let the block settle
  task automatic drain_results();
    unit_ch.valid <= 1'b0;
    // Wait for the clock so the monitor queues the beats of the last accepted unit
    @(posedge clk);
    while (utf8_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back while idle
  task automatic apply_config(input logic rep, input logic [23:0] cap);
    drain_results();
    cfg_we       <= 1'b1;
    cfg_index    <= CFG_REPLACE;
    cfg_data     <= CFG_DATA_W'(rep);
    mode_replace = rep;
    @(posedge clk);
    cfg_index    <= CFG_CAPACITY;
    cfg_data     <= cap;
    cap_limit    = cap;
    @(posedge clk);
    cfg_we       <= 1'b0;
  endtask

  // Build one region of random characters, mostly well formed, and send it
  task automatic send_random_region();
    logic [15:0] region_units[$];
    int n_chars;
    int pick;
    n_chars = $urandom_range(1, 6);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        region_units.push_back(16'h0000);
      end else if (pick < 35) begin
        region_units.push_back(16'($urandom_range(1, 'h7F)));
      end else if (pick < 50) begin
        region_units.push_back(16'($urandom_range('h80, 'h7FF)));
      end else if (pick < 58) begin
        region_units.push_back(16'($urandom_range('hE000, 'hFFFF)));
      end else if (pick < 66) begin
        region_units.push_back(16'($urandom_range('h800, 'hD7FF)));
      end else if (pick < 84) begin
        region_units.push_back(SURR_HI_FIRST + 16'($urandom_range(0, 'h3FF)));
        region_units.push_back(SURR_LO_FIRST + 16'($urandom_range(0, 'h3FF)));
      end else if (pick < 90) begin
        region_units.push_back(SURR_HI_FIRST + 16'($urandom_range(0, 'h3FF)));
      end else if (pick < 95) begin
        region_units.push_back(SURR_LO_FIRST + 16'($urandom_range(0, 'h3FF)));
      end else begin
        region_units.push_back(16'($urandom));
      end
    end
    foreach (region_units[i])
      send_unit(region_units[i], i == region_units.size() - 1, 1'b0, 3'd0, 32'd0);
  endtask

  function automatic stim_row_t unit_row(input logic [15:0] cu, input logic lu);
    stim_row_t row;
    row = '{ROW_UNIT, cu, lu, 1'b0, 3'd0, 32'd0, 1'b0, 24'd0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [15:0] cu, input logic [2:0] n,
                                          input logic [31:0] seq);
    stim_row_t row;
    row = '{ROW_UNIT, cu, 1'b1, 1'b1, n, seq, 1'b0, 24'd0};
    return row;
  endfunction

  function automatic stim_row_t config_row(input logic rep, input logic [23:0] cap);
    stim_row_t row;
    row = '{ROW_CONFIG, 16'd0, 1'b0, 1'b0, 3'd0, 32'd0, rep, cap};
    return row;
  endfunction

  initial begin : stimulus
    stim_row_t row;
    int phase_end;
    bit paused;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_REPLACE;
    cfg_data          <= '0;
    unit_ch.valid     <= 1'b0;
    unit_ch.code_unit <= '0;
    unit_ch.last_unit <= 1'b0;
    row_typed         <= 1'b0;
    row_ref_n         <= '0;
    row_ref_seq       <= '0;
    mode_replace = 1'b0;
    cap_limit    = CAP_FULL;
    pend_high    = '0;
    pend_valid   = 1'b0;
    region_bytes = '0;

    dir_rows = '{
      // reset defaults: strict mode, full capacity; one-unit regions at range edges
      typed_row(16'h0041, 3'd1, 32'h4100_0000),
      typed_row(16'h0000, 3'd0, 32'h0000_0000),
      typed_row(16'h007F, 3'd1, 32'h7F00_0000),
      typed_row(16'h0080, 3'd2, 32'hC280_0000),
      typed_row(16'h07FF, 3'd2, 32'hDFBF_0000),
      typed_row(16'h0800, 3'd3, 32'hE0A0_8000),
      typed_row(16'hFFFF, 3'd3, 32'hEFBF_BF00),
      // high surrogate on the last unit goes out as its own 3-byte form
      typed_row(16'hD800, 3'd3, 32'hEDA0_8000),
      // lone low surrogates
      unit_row(16'hDC00, 1'b0),
      unit_row(16'hDFFF, 1'b1),
      // lowest and highest surrogate pairs
      unit_row(16'hD800, 1'b0),
      unit_row(16'hDC00, 1'b1),
      unit_row(16'hDBFF, 1'b0),
      unit_row(16'hDFFF, 1'b1),
      // held high followed by a plain unit, then by another high on the last unit
      unit_row(16'hDBFF, 1'b0),
      unit_row(16'h0041, 1'b0),
      unit_row(16'hD800, 1'b0),
      unit_row(16'hD801, 1'b1),
      // held high followed by code point zero
      unit_row(16'hD800, 1'b0),
      unit_row(16'h0000, 1'b1),
      // replace mode
      config_row(1'b1, CAP_FULL),
      typed_row(16'hDC00, 3'd3, 32'hEFBF_BD00),
      unit_row(16'hD800, 1'b0),
      unit_row(16'h0800, 1'b1),
      // zero capacity drops everything
      config_row(1'b0, 24'd0),
      typed_row(16'h0041, 3'd0, 32'h0000_0000),
      // small capacity: a character that overruns is dropped, a later one still fits
      config_row(1'b1, 24'd5),
      unit_row(16'h0041, 1'b0),
      unit_row(16'h0800, 1'b0),
      unit_row(16'h0080, 1'b0),
      unit_row(16'h0041, 1'b1)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CONFIG)
        apply_config(row.cfg_replace, row.cfg_capacity);
      else
        send_unit(row.code_unit, row.last_unit, row.typed, row.ref_n, row.ref_seq);
    end

    // Random regions over several register settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       apply_config(1'b0, CAP_FULL);
        1:       apply_config(1'b1, 24'($urandom_range(6, 14)));
        2:       apply_config(1'b0, 24'($urandom_range(1, 30)));
        default: apply_config(1'b1, CAP_FULL);
      endcase
      sender_steady = (phase == 2);
      // back up the output while units keep coming
      if (phase == 1) rx_hold_req = 1'b1;
      paused = 1'b0;
      phase_end = units_accepted + PHASE_UNITS;
      while (units_accepted < phase_end) begin
        send_random_region();
        if (phase == 3 && !paused && units_accepted >= phase_end - PHASE_UNITS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
    sender_steady = 1'b0;

    drain_results();
    if (mismatches == 0 && utf8_expect_q.size() == 0) begin
      $display("** utf16_to_utf8_transcoder: PASSED **");
    end else begin
      $display("** utf16_to_utf8_transcoder: FAILED **");
    end
    $finish;
  end

endmodule
